### hdl/mpsm_pkg.sv
// ----------------------------------------------------------------------------
// mpsm_pkg: shared types and constants of the string matcher
// Holds opcodes, status codes and the record that travels between the
// front end and the back end.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned LetW  = 5;
  localparam int unsigned LenW  = 6;
  localparam int unsigned StatW = 2;

  typedef enum logic [OpW-1:0] {
    OP_START   = 3'd0,
    OP_ADD     = 3'd1,
    OP_END     = 3'd2,
    OP_BUILD   = 3'd3,
    OP_SCAN    = 3'd4,
    OP_RESTART = 3'd5
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_LONG     = 2'd2,
    ST_NO_LINKS = 2'd3
  } status_e;

  // One accepted transaction as held in the command queue.
  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [LetW-1:0] letter;
  } cmd_t;

endpackage

### hdl/mpsm_cmd_queue.sv
// ----------------------------------------------------------------------------
// mpsm_cmd_queue: front end command queue
// Accepts input transactions and holds them until the back end takes them.
// ----------------------------------------------------------------------------
module mpsm_cmd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mpsm_pkg::cmd_t      cmd_i,
  output logic                full_o,
  input  logic                take_i,
  output logic                avail_o,
  output mpsm_pkg::cmd_t      cmd_o
);
  import mpsm_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_push, do_take;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign avail_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_take = take_i && avail_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_take ? ((rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(do_push) - (AW+1)'(do_take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

### hdl/mpsm_engine.sv
// ----------------------------------------------------------------------------
// mpsm_engine: back end trie engine
// Sequencer that inserts letters, builds suffix and output links with a
// breadth-first pass, and scans text, writing results into an output queue.
// ----------------------------------------------------------------------------
module mpsm_engine #(
  parameter int unsigned NodeCount    = 256,
  parameter int unsigned AlphabetSize = 26,
  parameter int unsigned MaxDepth     = 32,
  parameter int unsigned ResultCap    = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          avail_i,
  input  mpsm_pkg::cmd_t                cmd_i,
  output logic                          take_o,
  output logic                          res_full_o,
  input  logic                          res_wr_ready_i,
  output logic                          res_wr_o,
  output logic                          res_found_o,
  output logic [7:0]                    res_node_o,
  output logic [mpsm_pkg::LenW-1:0]     res_len_o,
  output logic [mpsm_pkg::StatW-1:0]    res_status_o,
  output logic                          res_last_o
);
  import mpsm_pkg::*;

  localparam int unsigned NW   = $clog2(NodeCount);
  localparam int unsigned CW   = $clog2(AlphabetSize);
  localparam int unsigned TabN = NodeCount * AlphabetSize;
  localparam int unsigned TW   = $clog2(TabN);
  localparam int unsigned ClrN = (NodeCount > AlphabetSize) ? NodeCount : AlphabetSize;
  localparam int unsigned RW   = $clog2(ResultCap + 1);

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_ADD_RD  = 16'h0004,
    S_ADD_CHK = 16'h0008,
    S_END_RD  = 16'h0010,
    S_B_POP   = 16'h0020,
    S_B_KID   = 16'h0040,
    S_B_CHK   = 16'h0080,
    S_B_WALK  = 16'h0100,
    S_B_WKID  = 16'h0200,
    S_B_SET   = 16'h0400,
    S_SC_KID  = 16'h0800,
    S_SC_CHK  = 16'h1000,
    S_SC_NODE = 16'h2000,
    S_SC_OUT  = 16'h4000,
    S_EMIT    = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // Memories: child table (cleared by a sweep), per-node tables.
  logic [NW-1:0] child_mem [TabN];
  logic [NW-1:0] sfx_mem   [NodeCount];
  logic [NW:0]   out_mem   [NodeCount];
  logic          wflag_mem [NodeCount];
  logic [LenW-1:0] dep_mem [NodeCount];
  logic [NW-1:0] bfs_mem   [NodeCount];

  // Child table port.
  logic          ct_we;
  logic [TW-1:0] ct_wa, ct_ra;
  logic [NW-1:0] ct_wd, ct_rd_q;
  // Node table port (suffix, output, flag, depth share one address).
  logic          nd_we_sfx, nd_we_out, nd_we_flag, nd_we_dep;
  logic [NW-1:0] nd_wa, nd_ra;
  logic [NW-1:0] nd_wsfx;
  logic [NW:0]   nd_wout;
  logic          nd_wflag;
  logic [LenW-1:0] nd_wdep;
  logic [NW-1:0] sfx_rd_q;
  logic [NW:0]   out_rd_q;
  logic          flag_rd_q;
  logic [LenW-1:0] dep_rd_q;
  logic          q_we;
  logic [NW-1:0] q_wa, q_ra, q_wd, q_rd_q;

  always_ff @(posedge clk_i) begin
    if (ct_we) child_mem[ct_wa] <= ct_wd;
    ct_rd_q <= child_mem[ct_ra];
  end
  always_ff @(posedge clk_i) begin
    if (nd_we_sfx)  sfx_mem[nd_wa]   <= nd_wsfx;
    if (nd_we_out)  out_mem[nd_wa]   <= nd_wout;
    if (nd_we_flag) wflag_mem[nd_wa] <= nd_wflag;
    if (nd_we_dep)  dep_mem[nd_wa]   <= nd_wdep;
    sfx_rd_q  <= sfx_mem[nd_ra];
    out_rd_q  <= out_mem[nd_ra];
    flag_rd_q <= wflag_mem[nd_ra];
    dep_rd_q  <= dep_mem[nd_ra];
  end
  always_ff @(posedge clk_i) begin
    if (q_we) bfs_mem[q_wa] <= q_wd;
    q_rd_q <= bfs_mem[q_ra];
  end

  logic [TW-1:0]   clr_q, clr_d;
  logic [NW:0]     ncount_q, ncount_d;
  logic [NW-1:0]   ins_q, ins_d, scan_q, scan_d;
  logic            built_q, built_d;
  logic [StatW-1:0] werr_q, werr_d;
  cmd_t            cmd_q, cmd_d;
  // Scratch registers for build and scan.
  logic [NW-1:0]   t_q, t_d, cand_q, cand_d, ch_q, ch_d, s_q, s_d;
  logic [CW:0]     c_q, c_d;
  logic [NW:0]     head_q, head_d, tail_q, tail_d;
  logic [NW:0]     w_q, w_d;
  logic [RW-1:0]   k_q, k_d;
  // Pending result.
  logic            e_found_q, e_found_d;
  logic [NW-1:0]   e_node_q, e_node_d;
  logic [LenW-1:0] e_len_q, e_len_d;
  logic [StatW-1:0] e_stat_q, e_stat_d;
  logic            e_last_q, e_last_d;
  state_e          e_next_q, e_next_d;

  function automatic logic [TW-1:0] tidx(logic [NW-1:0] n, logic [CW:0] c);
    tidx = TW'(n * AlphabetSize) + TW'(c);
  endfunction

  logic let_ok;
  assign let_ok = (cmd_q.letter < LetW'(AlphabetSize));

  assign res_wr_o     = (state_q == S_EMIT) && res_wr_ready_i;
  assign res_found_o  = e_found_q;
  assign res_node_o   = 8'(e_node_q);
  assign res_len_o    = e_len_q;
  assign res_status_o = e_stat_q;
  assign res_last_o   = e_last_q;
  assign res_full_o   = !res_wr_ready_i;
  assign take_o       = (state_q == S_IDLE) && avail_i;

  always_comb begin
    state_d = state_q; clr_d = clr_q; ncount_d = ncount_q; ins_d = ins_q;
    scan_d = scan_q; built_d = built_q; werr_d = werr_q; cmd_d = cmd_q;
    t_d = t_q; cand_d = cand_q; ch_d = ch_q; s_d = s_q; c_d = c_q;
    head_d = head_q; tail_d = tail_q; w_d = w_q; k_d = k_q;
    e_found_d = e_found_q; e_node_d = e_node_q; e_len_d = e_len_q;
    e_stat_d = e_stat_q; e_last_d = e_last_q; e_next_d = e_next_q;
    ct_we = 1'b0; ct_wa = '0; ct_wd = '0; ct_ra = '0;
    nd_we_sfx = 1'b0; nd_we_out = 1'b0; nd_we_flag = 1'b0; nd_we_dep = 1'b0;
    nd_wa = '0; nd_ra = '0; nd_wsfx = '0; nd_wout = '0; nd_wflag = 1'b0;
    nd_wdep = '0; q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;

    unique case (state_q)
      S_CLEAR: begin
        // Sweep clears the child table; per-node tables clear alongside.
        ct_we = 1'b1; ct_wa = clr_q;
        if (clr_q < TW'(NodeCount)) begin
          nd_wa = NW'(clr_q); nd_we_sfx = 1'b1; nd_we_out = 1'b1;
          nd_we_flag = 1'b1; nd_we_dep = 1'b1;
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == TW'(TabN - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (avail_i) begin
          cmd_d = cmd_i;
          e_found_d = 1'b0; e_node_d = '0; e_len_d = '0; e_stat_d = ST_OK;
          e_last_d = 1'b1; e_next_d = S_IDLE;
          state_d = S_EMIT;
          case (cmd_i.op)
            OP_START: begin ins_d = '0; werr_d = ST_OK; end
            OP_ADD: begin
              if (werr_q != ST_OK) e_stat_d = werr_q;
              else if (cmd_i.letter < LetW'(AlphabetSize)) begin
                ct_ra = tidx(ins_q, (CW+1)'(cmd_i.letter));
                nd_ra = ins_q;
                state_d = S_ADD_RD;
              end
            end
            OP_END: begin
              if (werr_q != ST_OK) e_stat_d = werr_q;
              else if (ins_q != '0) begin nd_ra = ins_q; state_d = S_END_RD; end
              werr_d = ST_OK;
              if (!(werr_q == ST_OK && ins_q != '0)) ins_d = '0;
            end
            OP_BUILD: begin
              q_we = 1'b1; q_wa = '0; q_wd = '0;
              nd_we_sfx = 1'b1; nd_we_out = 1'b1; nd_wa = '0;
              head_d = '0; tail_d = (NW+1)'(1);
              state_d = S_B_POP;
            end
            OP_SCAN: begin
              if (!built_q) e_stat_d = ST_NO_LINKS;
              else begin
                cand_d = scan_q;
                ct_ra = tidx(scan_q, (CW+1)'(cmd_i.letter));
                nd_ra = scan_q;
                state_d = S_SC_KID;
              end
            end
            OP_RESTART: scan_d = '0;
            default: ;
          endcase
        end
      end
      S_ADD_RD: begin
        // Keep the insert cursor on the read ports for the check cycle.
        ct_ra = tidx(ins_q, (CW+1)'(cmd_q.letter));
        nd_ra = ins_q;
        state_d = S_ADD_CHK;
      end
      S_ADD_CHK: begin
        state_d = S_EMIT;
        if (dep_rd_q >= LenW'(MaxDepth)) begin
          e_stat_d = ST_LONG; werr_d = ST_LONG;
        end else if (ct_rd_q != '0) begin
          ins_d = ct_rd_q;
        end else if (ncount_q >= (NW+1)'(NodeCount)) begin
          e_stat_d = ST_FULL; werr_d = ST_FULL;
        end else begin
          ct_we = 1'b1; ct_wa = tidx(ins_q, (CW+1)'(cmd_q.letter));
          ct_wd = NW'(ncount_q);
          nd_wa = NW'(ncount_q);
          nd_we_sfx = 1'b1; nd_we_out = 1'b1; nd_we_flag = 1'b1; nd_we_dep = 1'b1;
          nd_wdep = dep_rd_q + 1'b1;
          ins_d = NW'(ncount_q);
          ncount_d = ncount_q + 1'b1;
          built_d = 1'b0;
        end
      end
      S_END_RD: begin
        if (!flag_rd_q) begin
          nd_we_flag = 1'b1; nd_wa = ins_q; nd_wflag = 1'b1; built_d = 1'b0;
        end
        ins_d = '0;
        state_d = S_EMIT;
      end
      S_B_POP: begin
        if (head_q == tail_q) begin
          built_d = 1'b1; state_d = S_EMIT;
        end else begin
          q_ra = NW'(head_q); head_d = head_q + 1'b1;
          c_d = '0; state_d = S_B_KID;
        end
      end
      S_B_KID: begin
        // q_rd_q holds t; fetch its child and its suffix link.
        t_d = q_rd_q;
        ct_ra = tidx(q_rd_q, c_q);
        nd_ra = q_rd_q;
        state_d = S_B_CHK;
      end
      S_B_CHK: begin
        if (ct_rd_q == '0) begin
          if (c_q == (CW+1)'(AlphabetSize - 1)) state_d = S_B_POP;
          else begin
            c_d = c_q + 1'b1; ct_ra = tidx(t_q, c_q + 1'b1); nd_ra = t_q;
            state_d = S_B_CHK;
          end
        end else begin
          ch_d = ct_rd_q;
          if (t_q == '0) begin
            s_d = '0; nd_ra = '0; state_d = S_B_SET;
          end else begin
            cand_d = sfx_rd_q;
            ct_ra = tidx(sfx_rd_q, c_q); nd_ra = sfx_rd_q;
            state_d = S_B_WALK;
          end
        end
      end
      S_B_WALK: begin
        // ct_rd_q = kid(cand,c); sfx_rd_q = suffix_link[cand].
        if (ct_rd_q == '0 && cand_q != '0) begin
          cand_d = sfx_rd_q;
          ct_ra = tidx(sfx_rd_q, c_q); nd_ra = sfx_rd_q;
          state_d = S_B_WALK;
        end else begin
          s_d = ct_rd_q; nd_ra = ct_rd_q; state_d = S_B_SET;
        end
      end
      S_B_WKID: state_d = S_B_SET;
      S_B_SET: begin
        nd_wa = ch_q; nd_we_sfx = 1'b1; nd_wsfx = s_q; nd_we_out = 1'b1;
        nd_wout = flag_rd_q ? ({1'b0, s_q} + 1'b1) : out_rd_q;
        if (tail_q < (NW+1)'(NodeCount)) begin
          q_we = 1'b1; q_wa = NW'(tail_q); q_wd = ch_q; tail_d = tail_q + 1'b1;
        end
        if (c_q == (CW+1)'(AlphabetSize - 1)) state_d = S_B_POP;
        else begin
          c_d = c_q + 1'b1; ct_ra = tidx(t_q, c_q + 1'b1); nd_ra = t_q;
          state_d = S_B_CHK;
        end
      end
      S_SC_KID: begin
        // ct_rd_q = kid(cand,c); sfx_rd_q = suffix_link[cand].
        if (!let_ok) begin
          scan_d = '0; e_stat_d = ST_OK; state_d = S_EMIT;
        end else if (ct_rd_q == '0 && cand_q != '0) begin
          cand_d = sfx_rd_q;
          ct_ra = tidx(sfx_rd_q, (CW+1)'(cmd_q.letter)); nd_ra = sfx_rd_q;
        end else begin
          scan_d = ct_rd_q; nd_ra = ct_rd_q; k_d = '0;
          if (ct_rd_q == '0) state_d = S_EMIT;
          else begin cand_d = ct_rd_q; state_d = S_SC_CHK; end
        end
      end
      S_SC_CHK: begin
        // Node data of the landing node is on the read port.
        w_d = out_rd_q;
        if (flag_rd_q) begin
          e_found_d = 1'b1; e_node_d = cand_q; e_len_d = dep_rd_q;
          k_d = RW'(1);
          e_last_d = (out_rd_q == '0) || (ResultCap == 1);
          e_next_d = S_SC_OUT; state_d = S_EMIT;
        end else if (out_rd_q == '0) begin
          // Nothing ends here: the pending no-match result closes the letter.
          state_d = S_EMIT;
        end else state_d = S_SC_OUT;
        if (out_rd_q != '0) nd_ra = NW'(out_rd_q - 1'b1);
      end
      S_SC_OUT: begin
        if (w_q == '0 || k_q >= RW'(ResultCap)) state_d = S_IDLE;
        else begin
          nd_ra = NW'(w_q - 1'b1); state_d = S_SC_NODE;
        end
      end
      S_SC_NODE: begin
        e_found_d = 1'b1; e_node_d = NW'(w_q - 1'b1); e_len_d = dep_rd_q;
        e_stat_d = ST_OK; w_d = out_rd_q; k_d = k_q + 1'b1;
        e_last_d = (out_rd_q == '0) || (k_q + 1'b1 >= RW'(ResultCap));
        e_next_d = S_SC_OUT; state_d = S_EMIT;
      end
      S_EMIT: begin
        if (res_wr_ready_i) state_d = e_next_q;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; ncount_q <= (NW+1)'(1);
      ins_q <= '0; scan_q <= '0; built_q <= 1'b0; werr_q <= ST_OK;
      e_next_q <= S_IDLE; head_q <= '0; tail_q <= '0; k_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; ncount_q <= ncount_d;
      ins_q <= ins_d; scan_q <= scan_d; built_q <= built_d; werr_q <= werr_d;
      e_next_q <= e_next_d; head_q <= head_d; tail_q <= tail_d; k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; t_q <= t_d; cand_q <= cand_d; ch_q <= ch_d; s_q <= s_d;
    c_q <= c_d; w_q <= w_d; e_found_q <= e_found_d; e_node_q <= e_node_d;
    e_len_q <= e_len_d; e_stat_q <= e_stat_d; e_last_q <= e_last_d;
  end

endmodule

### hdl/mpsm_res_queue.sv
// ----------------------------------------------------------------------------
// mpsm_res_queue: result queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module mpsm_res_queue #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             do_wr, do_rd;

  assign ready_o = (cnt_q != (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && ready_o;
  assign do_rd   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (do_wr) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (do_rd) rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_q] <= data_i;
  end

endmodule

### hdl/multi_pattern_string_matcher.sv
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher: Aho-Corasick dictionary matcher
// Builds a trie of words, links it, and scans text letter by letter.
// ----------------------------------------------------------------------------
// Each transaction pushed in is queued, then executed by a sequencer that
// owns the trie memories, and its results are written into a result queue.
// After reset the sequencer sweeps the child table, one entry per cycle,
// before it executes the first queued transaction. A scan letter follows
// suffix links from the scan node until the letter has a child there or
// the root is reached; it then reports a match if a word ends at the
// landing node and each match along the output chain, until the chain
// ends or the result cap stops the walk. A build visits the nodes breadth
// first, checks every letter of each node, and follows suffix links to
// link each child. Each result passes through the emit state, and the
// sequencer waits there while the result queue is full.
module multi_pattern_string_matcher #(
  parameter int unsigned NODE_COUNT    = 256,
  parameter int unsigned ALPHABET_SIZE = 26,
  parameter int unsigned MAX_DEPTH     = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [mpsm_pkg::OpW-1:0]        opcode_i,
  input  logic [mpsm_pkg::LetW-1:0]       letter_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            match_found_o,
  output logic [7:0]                      match_node_o,
  output logic [mpsm_pkg::LenW-1:0]       match_length_o,
  output logic [mpsm_pkg::StatW-1:0]      status_o,
  output logic                            last_o
);
  import mpsm_pkg::*;

  localparam int unsigned ResW = 1 + 8 + LenW + StatW + 1;

  cmd_t in_cmd, eng_cmd;
  logic avail, take, rq_ready, rq_wr, res_full;
  logic r_found, r_last;
  logic [7:0] r_node;
  logic [LenW-1:0] r_len;
  logic [StatW-1:0] r_stat;
  logic [ResW-1:0] rq_in, rq_out;

  assign in_cmd.op     = opcode_i;
  assign in_cmd.letter = letter_i;

  mpsm_cmd_queue #(.Depth(4)) u_cmdq (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(in_cmd), .full_o(full),
    .take_i(take), .avail_o(avail), .cmd_o(eng_cmd)
  );

  mpsm_engine #(
    .NodeCount(NODE_COUNT), .AlphabetSize(ALPHABET_SIZE),
    .MaxDepth(MAX_DEPTH), .ResultCap(32)
  ) u_eng (
    .clk_i, .rst_ni, .avail_i(avail), .cmd_i(eng_cmd), .take_o(take),
    .res_full_o(res_full), .res_wr_ready_i(rq_ready), .res_wr_o(rq_wr),
    .res_found_o(r_found), .res_node_o(r_node), .res_len_o(r_len),
    .res_status_o(r_stat), .res_last_o(r_last)
  );

  assign rq_in = {r_found, r_node, r_len, r_stat, r_last};

  mpsm_res_queue #(.Depth(4), .Width(ResW)) u_resq (
    .clk_i, .rst_ni, .wr_i(rq_wr && !res_full), .data_i(rq_in),
    .ready_o(rq_ready), .pop_i(pop), .empty_o(empty), .data_o(rq_out)
  );

  assign {match_found_o, match_node_o, match_length_o, status_o, last_o} = rq_out;

endmodule

### hdl/mpsm_checker.sv
// ----------------------------------------------------------------------------
// mpsm_checker: port-level checks of the matcher
// Watches the result port for consistent result records.
// ----------------------------------------------------------------------------
module mpsm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       match_found_o,
  input logic [7:0] match_node_o,
  input logic [5:0] match_length_o,
  input logic [1:0] status_o,
  input logic       last_o
);
  // A no-match result always closes its transaction.
  a_nomatch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !match_found_o) |-> last_o) else $error("no-match not last");

  // A reported match has ok status and a nonzero node.
  a_match_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && match_found_o) |-> (status_o == 2'd0 && match_node_o != 8'd0))
    else $error("bad match record");

  // A no-match result carries zero node and length.
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !match_found_o) |-> (match_node_o == 8'd0 && match_length_o == 6'd0))
    else $error("no-match payload not zero");

  // A waiting result holds until popped.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(match_node_o) && $stable(last_o)))
    else $error("result changed while waiting");
endmodule

bind multi_pattern_string_matcher mpsm_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .match_found_o, .match_node_o,
  .match_length_o, .status_o, .last_o
);

### tb/multi_pattern_string_matcher_test.sv
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_test: self-checking bench of the string matcher
// Drives directed transactions, a too-long word, random dictionaries and text
// and a full trie. Every result is checked against an Aho-Corasick predictor.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher_test;
  import mpsm_pkg::*;

  localparam int NODES = 256;
  localparam int ALPHA = 26;
  localparam int DEPTH_MAX = 32;
  localparam int MATCH_CAP = 32;

  // One expected or observed result.
  typedef struct packed {
    logic       found;
    logic [7:0] node;
    logic [5:0] len;
    logic [1:0] status;
    logic       last;
  } match_t;

  // One directed row: the transaction, and optionally a typed-in result.
  typedef struct {
    op_e        op;
    logic [4:0] letter;
    bit         typed;
    match_t     want;
  } row_t;

  logic clk, rst_n;
  logic push, full, empty, pop;
  logic [OpW-1:0] opcode;
  logic [LetW-1:0] letter;
  logic found_o, last_o;
  logic [7:0] node_o;
  logic [LenW-1:0] len_o;
  logic [StatW-1:0] status_o;

  multi_pattern_string_matcher dut (
    .clk_i(clk), .rst_ni(rst_n),
    .push(push), .full(full), .opcode_i(opcode), .letter_i(letter),
    .empty(empty), .pop(pop),
    .match_found_o(found_o), .match_node_o(node_o), .match_length_o(len_o),
    .status_o(status_o), .last_o(last_o)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Predictor copy of the trie and scan state.
  int unsigned trie_child [NODES*ALPHA];
  int unsigned fail_link [NODES];
  int unsigned dict_link [NODES];   // node id + 1, zero when none
  bit          is_word [NODES];
  int unsigned depth_of [NODES];
  int unsigned nodes_used, ins_at, scan_at, word_err;
  bit          linked;

  match_t pending_matches[$];
  int errors;
  int hold_cycles;   // long receiver hold-off, set by the stimulus process

  function automatic int unsigned child_of(int unsigned n, int unsigned c);
    if (n >= NODES || c >= ALPHA) return 0;
    return trie_child[n*ALPHA + c];
  endfunction

  function automatic match_t mk(bit f, int unsigned n, int unsigned l,
                                status_e s, bit lst);
    match_t m;
    m.found = f; m.node = n[7:0]; m.len = l[5:0]; m.status = s; m.last = lst;
    return m;
  endfunction

  function automatic void trie_clear();
    for (int i = 0; i < NODES*ALPHA; i++) trie_child[i] = 0;
    for (int i = 0; i < NODES; i++) begin
      fail_link[i] = 0; dict_link[i] = 0; is_word[i] = 0; depth_of[i] = 0;
    end
    nodes_used = 1; ins_at = 0; scan_at = 0; word_err = 0; linked = 0;
  endfunction

  // Breadth-first pass setting suffix and dictionary links.
  function automatic void link_trie();
    int unsigned fifo[$];
    int unsigned t, ch, s, cand;
    fifo.push_back(0);
    fail_link[0] = 0; dict_link[0] = 0;
    while (fifo.size() > 0) begin
      t = fifo.pop_front();
      for (int unsigned c = 0; c < ALPHA; c++) begin
        ch = child_of(t, c);
        if (ch == 0) continue;
        if (t == 0) s = 0;
        else begin
          cand = fail_link[t];
          while (child_of(cand, c) == 0 && cand != 0) cand = fail_link[cand];
          s = child_of(cand, c);
        end
        fail_link[ch] = s;
        dict_link[ch] = is_word[s] ? s + 1 : dict_link[s];
        fifo.push_back(ch);
      end
    end
    linked = 1;
  endfunction

  // Applies one transaction to the predictor and queues its results.
  function automatic void predict_matches(op_e op, logic [4:0] c);
    status_e st = ST_OK;
    int unsigned cur, nx, w, k;
    case (op)
      OP_START: begin ins_at = 0; word_err = 0; end
      OP_ADD: begin
        if (word_err != 0) st = status_e'(word_err);
        else if (c < ALPHA) begin
          nx = child_of(ins_at, c);
          if (depth_of[ins_at] >= DEPTH_MAX) begin
            word_err = ST_LONG; st = ST_LONG;
          end else if (nx != 0) ins_at = nx;
          else if (nodes_used >= NODES) begin
            word_err = ST_FULL; st = ST_FULL;
          end else begin
            nx = nodes_used++;
            trie_child[ins_at*ALPHA + c] = nx;
            depth_of[nx] = depth_of[ins_at] + 1;
            fail_link[nx] = 0; dict_link[nx] = 0; is_word[nx] = 0;
            ins_at = nx; linked = 0;
          end
        end
      end
      OP_END: begin
        if (word_err != 0) st = status_e'(word_err);
        else if (ins_at != 0 && !is_word[ins_at]) begin
          is_word[ins_at] = 1; linked = 0;
        end
        word_err = 0; ins_at = 0;
      end
      OP_BUILD: link_trie();
      OP_SCAN: begin
        if (!linked) begin
          pending_matches.push_back(mk(0, 0, 0, ST_NO_LINKS, 1));
          return;
        end
        cur = scan_at;
        while (child_of(cur, c) == 0 && cur != 0) cur = fail_link[cur];
        cur = child_of(cur, c);
        scan_at = cur;
        k = 0;
        if (cur != 0 && is_word[cur]) begin
          pending_matches.push_back(mk(1, cur, depth_of[cur], ST_OK, 0));
          k++;
        end
        w = (cur != 0) ? dict_link[cur] : 0;
        while (w != 0 && k < MATCH_CAP) begin
          pending_matches.push_back(mk(1, w-1, depth_of[w-1], ST_OK, 0));
          k++;
          w = dict_link[w-1];
        end
        if (k == 0) pending_matches.push_back(mk(0, 0, 0, ST_OK, 1));
        else pending_matches[$].last = 1'b1;
        return;
      end
      OP_RESTART: scan_at = 0;
      default: ;
    endcase
    pending_matches.push_back(mk(0, 0, 0, st, 1));
  endfunction

  // Directed table. Typed rows carry results readable at a glance.
  row_t directed[$];
  function automatic void add_row(op_e op, int l, bit typed = 0,
                                  match_t want = '0);
    row_t r;
    r.op = op; r.letter = l[4:0]; r.typed = typed; r.want = want;
    directed.push_back(r);
  endfunction

  int unsigned sent;

  task automatic send(logic [OpW-1:0] op, logic [4:0] l);
    repeat ($urandom_range(0, 8)) @(negedge clk);
    push = 1'b1; opcode = op; letter = l;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_matches(op_e'(op), l);
    sent++;
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic send_word(int n, int unsigned top = 3);
    send(OP_START, 0);
    for (int i = 0; i < n; i++) send(OP_ADD, LetW'($urandom_range(0, top)));
    send(OP_END, 0);
  endtask

  // Receiver: a random wait before each pop, and one long
  // hold-off counted here when the stimulus asks for it.
  always begin : receiver
    int gap;
    @(negedge clk);
    if (!rst_n) pop = 1'b0;
    else begin
      gap = $urandom_range(0, 8);
      if (gap > 0 || hold_cycles > 0) pop = 1'b0;
      repeat (gap) @(negedge clk);
      while (hold_cycles > 0) begin
        hold_cycles--;
        @(negedge clk);
      end
      pop = 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // Compare each popped result with the oldest expectation.
  always @(posedge clk) begin
    match_t got, exp;
    if (rst_n && pop && !empty) begin
      got = {found_o, node_o, len_o, status_o, last_o};
      if (pending_matches.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        exp = pending_matches.pop_front();
        if (got !== exp) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected f=%0d n=%0d l=%0d s=%0d last=%0d,",
                      " got f=%0d n=%0d l=%0d s=%0d last=%0d"},
                     exp.found, exp.node, exp.len, exp.status, exp.last,
                     got.found, got.node, got.len, got.status, got.last);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    match_t typed_want;
    int n;
    errors = 0; hold_cycles = 0;
    rst_n = 1'b0; push = 1'b0; opcode = '0; letter = '0;
    trie_clear();
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Scan before build, out-of-alphabet add, empty word, unused opcode,
    // then words with the widest letters and a scan pass with overlaps.
    add_row(OP_SCAN, 0, 1, mk(0, 0, 0, ST_NO_LINKS, 1));
    add_row(OP_START, 0, 1, mk(0, 0, 0, ST_OK, 1));
    add_row(OP_END, 0, 1, mk(0, 0, 0, ST_OK, 1));
    add_row(OP_ADD, 31, 1, mk(0, 0, 0, ST_OK, 1));
    add_row(OP_ADD, 25);  add_row(OP_ADD, 0);  add_row(OP_END, 0);
    add_row(OP_ADD, 0);   add_row(OP_END, 0);   // word "a" without start
    add_row(OP_START, 0); add_row(OP_ADD, 26); add_row(OP_ADD, 0);
    add_row(OP_END, 0);
    add_row(OP_BUILD, 0);
    add_row(OP_SCAN, 25); add_row(OP_SCAN, 0); add_row(OP_SCAN, 0);
    add_row(OP_SCAN, 31); add_row(OP_SCAN, 16);
    add_row(OP_RESTART, 0);
    for (int i = 0; i < directed.size(); i++) begin
      typed_want = directed[i].want;
      send(directed[i].op, directed[i].letter);
      if (directed[i].typed && pending_matches[$] !== typed_want) begin
        errors++;
        if (errors <= 10) $display("directed row %0d predicted wrongly", i);
      end
    end
    send(3'd6, 5'd31); send(3'd7, 5'd10);

    // Word too long: 33 letters, then a repeat and an end carrying status.
    send(OP_START, 0);
    for (int i = 0; i < 34; i++) send(OP_ADD, 7);
    send(OP_END, 0);

    // Receiver holds off while the sender keeps pushing.
    hold_cycles = 400;
    for (int i = 0; i < 24; i++) send(OP_SCAN, LetW'($urandom_range(0, 31)));
    send(OP_BUILD, 0);

    // Random dictionaries over a small alphabet, then text scans.
    while (sent < 120) begin
      n = $urandom_range(2, 6);
      for (int w = 0; w < n; w++) send_word($urandom_range(1, 5));
      send(OP_BUILD, 0);
      for (int i = 0; i < 25; i++) begin
        case ($urandom_range(0, 19))
          0: send(OP_RESTART, 0);
          1: send(OpW'($urandom_range(0, 7)), LetW'($urandom));
          default: send(OP_SCAN, LetW'(($urandom_range(0, 9) == 0) ?
                        $urandom_range(0, 31) : $urandom_range(0, 3)));
        endcase
      end
    end

    // Fill the node table to hit the full status, then build and scan.
    while (nodes_used < NODES) send_word(30, ALPHA - 1);
    send(OP_START, 0);
    send(OP_ADD, 25); send(OP_ADD, 24);
    send(OP_END, 0);
    send(OP_BUILD, 0);
    for (int i = 0; i < 10; i++) send(OP_SCAN, LetW'($urandom_range(0, 3)));

    while (pending_matches.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

### filelist.f
hdl/mpsm_pkg.sv
hdl/mpsm_cmd_queue.sv
hdl/mpsm_engine.sv
hdl/mpsm_res_queue.sv
hdl/multi_pattern_string_matcher.sv
hdl/mpsm_checker.sv
tb/multi_pattern_string_matcher_test.sv
